// ===== rtl/lom_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and result codes for the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

	typedef enum logic [2:0] {
		KIND_TRADE     = 3'd0,
		KIND_RESTED    = 3'd1,
		KIND_FILLED    = 3'd2,
		KIND_DUPLICATE = 3'd3,
		KIND_CANCELLED = 3'd4,
		KIND_NOT_FOUND = 3'd5,
		KIND_BOOK_FULL = 3'd6
	} kind_t;

	localparam logic OP_SUBMIT = 1'b0;
	localparam logic OP_CANCEL = 1'b1;
	localparam logic SIDE_BUY  = 1'b0;

	// one request as it sits in the queue between front and back
	typedef struct packed {
		logic        op;
		logic [31:0] order_id;
		logic        side;
		logic [19:0] limit_price;
		logic [23:0] quantity;
		logic [47:0] stamp;
	} req_t;

	localparam int REQ_W = $bits(req_t);

endpackage
`default_nettype wire

// ===== rtl/lom_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_queue
// Two-entry request queue between the front end and the matching engine.
// ----------------------------------------------------------------------------
module lom_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lom_pkg::req_t       push_req,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output lom_pkg::req_t       head
);

	lom_pkg::req_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && not_empty) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && pop && !push) |=> count_q == 2'd0)
		else $error("queue pop lost");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && push && !pop) |=> count_q == 2'd1)
		else $error("queue push lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/lom_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_engine
// Matching engine: walks the book one entry a cycle to find the id and the
// best crossing entry, then fills, rests or reports.
// ----------------------------------------------------------------------------
module lom_engine #(
	parameter int BOOK_ENTRIES = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  lom_pkg::req_t       req,
	output logic                req_pop,
	output logic                res_valid,
	output lom_pkg::kind_t      res_kind,
	output logic [31:0]         res_trade_number,
	output logic [31:0]         res_buyer_id,
	output logic [31:0]         res_seller_id,
	output logic [19:0]         res_fill_price,
	output logic [23:0]         res_fill_quantity,
	output logic [47:0]         res_fill_stamp,
	output logic                res_last
);

	localparam int IW = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
	localparam int CW = IW + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_IDSCN = 6'b000010,
		ST_BEST  = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		logic        side;
		logic [31:0] id;
		logic [19:0] price;
		logic [23:0] remaining;
		logic [47:0] stamp;
		logic [31:0] arrival;
	} entry_t;

	entry_t mem_q [BOOK_ENTRIES];
	logic [BOOK_ENTRIES-1:0] valid_q;

	state_t        state_q;
	lom_pkg::req_t cur_q;
	logic [CW-1:0] scan_q;
	entry_t        rd_q;
	logic          rd_ok_q;
	logic [IW-1:0] rd_idx_q;
	logic          found_q;
	logic [IW-1:0] best_q;
	logic [19:0]   best_price_q;
	logic [31:0]   best_age_q;
	logic          free_ok_q;
	logic [IW-1:0] free_q;
	logic [31:0]   arrival_q;
	logic [31:0]   trade_q;
	entry_t        bent_q;
	lom_pkg::kind_t status_q;

	logic [IW-1:0] scan_idx;
	logic          scan_end;
	logic          crosses;
	logic          better;
	logic [31:0]   age;
	logic [23:0]   fill;
	logic [23:0]   left;
	logic [IW-1:0] free_idx;

	assign scan_idx = scan_q[IW-1:0];
	assign scan_end = (scan_q == CW'(BOOK_ENTRIES));
	assign age      = arrival_q - rd_q.arrival;
	assign crosses  = (cur_q.side == lom_pkg::SIDE_BUY) ? (rd_q.price <= cur_q.limit_price)
	                                                    : (rd_q.price >= cur_q.limit_price);
	always_comb begin
		if (!found_q) begin
			better = 1'b1;
		end else if (rd_q.price != best_price_q) begin
			better = (cur_q.side == lom_pkg::SIDE_BUY) ? (rd_q.price < best_price_q)
			                                           : (rd_q.price > best_price_q);
		end else begin
			better = age > best_age_q;
		end
	end
	assign fill = (cur_q.quantity < bent_q.remaining) ? cur_q.quantity : bent_q.remaining;
	assign left = cur_q.quantity - fill;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int k = BOOK_ENTRIES - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_idx = IW'(k);
			end
		end
	end

	assign req_pop = (state_q == ST_IDLE) && req_valid;

	// registered read of one entry a cycle
	always_ff @(posedge clk) begin
		rd_q     <= mem_q[scan_idx];
		rd_idx_q <= scan_idx;
		if (state_q == ST_FILL) begin
			bent_q <= mem_q[best_q];
		end
		if (state_q == ST_WRITE && found_q) begin
			mem_q[best_q].remaining <= bent_q.remaining - fill;
		end
		if (state_q == ST_DONE && status_q == lom_pkg::KIND_RESTED) begin
			mem_q[free_q] <= '{side: cur_q.side, id: cur_q.order_id,
				price: cur_q.limit_price, remaining: cur_q.quantity,
				stamp: cur_q.stamp, arrival: arrival_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			arrival_q <= '0;
			trade_q   <= 32'd1;
			res_valid <= 1'b0;
			rd_ok_q   <= 1'b0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_ok_q <= 1'b0;
					scan_q  <= '0;
					if (req_valid) begin
						cur_q     <= req;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						state_q   <= ST_IDSCN;
					end
				end
				ST_IDSCN: begin
					// advance the read; evaluate the entry read last cycle
					if (!scan_end) begin
						scan_q <= scan_q + CW'(1);
					end
					rd_ok_q <= !scan_end;
					if (rd_ok_q && valid_q[rd_idx_q] && rd_q.id == cur_q.order_id
					    && !found_q) begin
						found_q <= 1'b1;
						best_q  <= rd_idx_q;
					end
					if (rd_ok_q && !valid_q[rd_idx_q] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= rd_idx_q;
					end
					if (scan_end && !rd_ok_q) begin
						if (cur_q.op == lom_pkg::OP_CANCEL) begin
							status_q <= found_q ? lom_pkg::KIND_CANCELLED
							                    : lom_pkg::KIND_NOT_FOUND;
							if (found_q) begin
								valid_q[best_q] <= 1'b0;
							end
							state_q <= ST_DONE;
						end else if (found_q) begin
							status_q <= lom_pkg::KIND_DUPLICATE;
							state_q  <= ST_DONE;
						end else if (cur_q.quantity == 24'd0) begin
							status_q <= lom_pkg::KIND_FILLED;
							state_q  <= ST_DONE;
						end else begin
							scan_q  <= '0;
							state_q <= ST_BEST;
						end
					end
				end
				ST_BEST: begin
					if (!scan_end) begin
						scan_q <= scan_q + CW'(1);
					end
					rd_ok_q <= !scan_end;
					if (rd_ok_q && valid_q[rd_idx_q] && rd_q.side != cur_q.side
					    && crosses && better) begin
						found_q      <= 1'b1;
						best_q       <= rd_idx_q;
						best_price_q <= rd_q.price;
						best_age_q   <= age;
					end
					if (scan_end && !rd_ok_q) begin
						if (found_q) begin
							state_q <= ST_FILL;
						end else begin
							// no cross left: rest the remainder if a slot is free
							free_ok_q <= 1'b0;
							scan_q    <= '0;
							state_q   <= ST_WRITE;
							status_q  <= lom_pkg::KIND_BOOK_FULL;
						end
					end
				end
				ST_FILL: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (found_q) begin
						res_valid         <= 1'b1;
						res_kind          <= lom_pkg::KIND_TRADE;
						res_trade_number  <= trade_q;
						res_buyer_id      <= (cur_q.side == lom_pkg::SIDE_BUY)
						                     ? cur_q.order_id : bent_q.id;
						res_seller_id     <= (cur_q.side == lom_pkg::SIDE_BUY)
						                     ? bent_q.id : cur_q.order_id;
						res_fill_price    <= bent_q.price;
						res_fill_quantity <= fill;
						res_fill_stamp    <= (cur_q.stamp > bent_q.stamp)
						                     ? cur_q.stamp : bent_q.stamp;
						res_last          <= 1'b0;
						trade_q           <= trade_q + 32'd1;
						cur_q.quantity    <= left;
						if (bent_q.remaining == fill) begin
							valid_q[best_q] <= 1'b0;
						end
						found_q <= 1'b0;
						rd_ok_q <= 1'b0;
						scan_q  <= '0;
						if (left == 24'd0) begin
							status_q <= lom_pkg::KIND_FILLED;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_BEST;
						end
					end else begin
						// first free slot from the current valid bits
						free_ok_q <= ~&valid_q;
						free_q    <= free_idx;
						status_q  <= (~&valid_q) ? lom_pkg::KIND_RESTED
						                         : lom_pkg::KIND_BOOK_FULL;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_valid         <= 1'b1;
					res_kind          <= status_q;
					res_trade_number  <= '0;
					res_buyer_id      <= '0;
					res_seller_id     <= '0;
					res_fill_price    <= '0;
					res_fill_quantity <= '0;
					res_fill_stamp    <= '0;
					res_last          <= 1'b1;
					if (status_q == lom_pkg::KIND_RESTED) begin
						valid_q[free_q] <= 1'b1;
						arrival_q       <= arrival_q + 32'd1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("engine state not one-hot");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (res_valid && res_last)) else $error("status missing");
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_kind == lom_pkg::KIND_TRADE) |-> !res_last)
		else $error("trade flagged last");
	a_trade_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_kind == lom_pkg::KIND_TRADE) |-> res_trade_number == $past(trade_q))
		else $error("trade number slip");
`endif

endmodule
`default_nettype wire

// ===== rtl/limit_order_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority limit order book with submit and cancel requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; it drops into a
// two-deep queue, so busy rises only once the queue is full. The matching
// engine then handles one request at a time: it takes the request from the
// queue in the idle state, then scans the book for its id. A cancel, a
// duplicate or a zero quantity then goes to the report state, and its
// status strobes in the cycle after it. A submit runs a best-price search,
// then reads the best entry and fills it, which strobes a trade; a search
// that finds no cross instead picks a slot and reports, ending the request
// the same way, while a fill that leaves nothing goes straight to the
// status cycle. Results appear with valid high for one cycle each, trades
// first, then exactly one status with last set; the receiver cannot stall
// them, so it must take every strobe.
module limit_order_matcher #(
	parameter int BOOK_ENTRIES = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         op,
	input  wire  [31:0] order_id,
	input  wire         side,
	input  wire  [19:0] limit_price,
	input  wire  [23:0] quantity,
	input  wire  [47:0] stamp,
	output logic        valid,
	output logic [2:0]  kind,
	output logic [31:0] trade_number,
	output logic [31:0] buyer_id,
	output logic [31:0] seller_id,
	output logic [19:0] fill_price,
	output logic [23:0] fill_quantity,
	output logic [47:0] fill_stamp,
	output logic        last
);

	lom_pkg::req_t  in_req;
	lom_pkg::req_t  head;
	lom_pkg::kind_t eng_kind;
	logic           q_full;
	logic           q_ne;
	logic           pop;

	// pack the request fields for the queue
	assign in_req = '{op: op, order_id: order_id, side: side,
		limit_price: limit_price, quantity: quantity, stamp: stamp};
	assign busy = q_full;
	assign kind = eng_kind;

	lom_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_req  (in_req),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.head      (head)
	);

	lom_engine #(.BOOK_ENTRIES(BOOK_ENTRIES)) u_engine (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (q_ne),
		.req               (head),
		.req_pop           (pop),
		.res_valid         (valid),
		.res_kind          (eng_kind),
		.res_trade_number  (trade_number),
		.res_buyer_id      (buyer_id),
		.res_seller_id     (seller_id),
		.res_fill_price    (fill_price),
		.res_fill_quantity (fill_quantity),
		.res_fill_stamp    (fill_stamp),
		.res_last          (last)
	);

endmodule
`default_nettype wire
